FILE: hdl/sbs_pkg.sv
// sbs_pkg: shared types, constants and lookup tables for the spectrum bar
// smoother with peak hold. No dependencies; imported by every hdl/ module.
`default_nettype none

package sbs_pkg;

  localparam int BANDS_DEF   = 32;
  localparam int PIPE_DEPTH  = 6;
  localparam int DT_MAX      = 100;
  localparam int LEVELS      = 256;

  localparam int FULL_SCALE_Q10 = 57344;
  localparam int LEVEL_MAX      = 255;
  localparam int VEL_GAIN       = 30720;
  localparam int VEL_SCALE      = 1000;
  localparam longint unsigned EXP_STEP_Q32 = 64'd4184737345;

  localparam logic [15:0] FIX_SMOOTH  = 16'd22938;
  localparam logic [31:0] ROUND_HALF  = 32'd32768;
  localparam logic [15:0] ONE_PX_Q10  = 16'd1024;
  localparam logic [22:0] FALL_ROUND  = 23'd250;
  // floor(z / 125) == (z * FALL_RECIP) >> FALL_SHIFT for z < 2^21
  localparam logic [21:0] FALL_RECIP  = 22'd2147484;
  localparam int          FALL_SHIFT  = 28;
  localparam logic [5:0]  LOW_TOP_DEF = 6'd28;
  localparam logic [5:0]  MID_TOP_DEF = 6'd45;

  typedef enum logic [1:0] {
    CFG_SMOOTHING_MODE = 2'd0,
    CFG_LOW_ZONE_TOP   = 2'd1,
    CFG_MID_ZONE_TOP   = 2'd2
  } cfg_reg_t;

  typedef logic [15:0] tgt_rom_t [LEVELS];
  typedef logic [15:0] fac_rom_t [DT_MAX+1];
  typedef logic [11:0] vinc_rom_t [DT_MAX+1];

  typedef struct packed {
    logic [15:0] bar;
    logic [15:0] peak;
    logic [15:0] vel;
  } band_state_t;

  typedef struct packed {
    logic [4:0]  idx;
    logic [15:0] target;
    logic [6:0]  ms;
    logic [15:0] factor;
    logic [11:0] vinc;
  } front_t;

  typedef struct packed {
    logic [4:0]  idx;
    logic [6:0]  ms;
    logic [15:0] bar;
    logic        ge;
    logic [15:0] peak;
    logic [15:0] vel;
  } s4_t;

  typedef struct packed {
    logic [5:0] low;
    logic [5:0] mid;
  } zone_cfg_t;

  typedef struct packed {
    logic [4:0] band;
    logic [5:0] bar_px;
    logic [5:0] peak_px;
    logic       shown;
    logic [5:0] lo;
    logic [5:0] mid;
    logic [5:0] top;
  } result_t;

  function automatic tgt_rom_t make_tgt_rom();
    tgt_rom_t rom;
    for (int i = 0; i < LEVELS; i++) begin
      rom[i] = 16'((i * FULL_SCALE_Q10 + LEVEL_MAX / 2) / LEVEL_MAX);
    end
    return rom;
  endfunction

  function automatic fac_rom_t make_fac_rom();
    fac_rom_t rom;
    longint unsigned p;
    p = 64'd1 << 32;
    for (int k = 0; k <= DT_MAX; k++) begin
      rom[k] = 16'(64'd65536 - ((p + 64'd32768) >> 16));
      p = (p * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    return rom;
  endfunction

  function automatic vinc_rom_t make_vinc_rom();
    vinc_rom_t rom;
    for (int k = 0; k <= DT_MAX; k++) begin
      rom[k] = 12'((VEL_GAIN * k + VEL_SCALE / 2) / VEL_SCALE);
    end
    return rom;
  endfunction

  localparam tgt_rom_t  TGT_ROM  = make_tgt_rom();
  localparam fac_rom_t  FAC_ROM  = make_fac_rom();
  localparam vinc_rom_t VINC_ROM = make_vinc_rom();

endpackage

`default_nettype wire

FILE: hdl/sbs_state_ram.sv
// sbs_state_ram: per-band bar/peak/velocity store, one write and one
// registered read port, with per-entry written flags. Uses sbs_pkg.
`default_nettype none

module sbs_state_ram import sbs_pkg::*; #(
  parameter int BANDS  = BANDS_DEF,
  parameter int SLOT_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [SLOT_W-1:0] rd_slot,
  output band_state_t            rd_state,
  input  wire logic              wr_en,
  input  wire logic [SLOT_W-1:0] wr_slot,
  input  band_state_t            wr_state
);

  band_state_t      mem [BANDS];
  band_state_t      rd_data;
  logic [BANDS-1:0] written;
  logic             rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_state;
    end
    if (rd_en) begin
      rd_data <= mem[rd_slot];
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_slot] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= written[rd_slot];
      end
    end
  end

  assign rd_state = rd_hit ? rd_data : '0;

endmodule

`default_nettype wire

FILE: hdl/sbs_smooth.sv
// sbs_smooth: bar smoothing stages 2..4 (distance, multiply, step and
// peak compare / velocity accumulate). Uses sbs_pkg.
`default_nettype none

module sbs_smooth import sbs_pkg::*; (
  input  wire logic clk,
  input  wire logic adv,
  input  front_t    front,
  input  band_state_t old_state,
  output s4_t       s4
);

  typedef struct packed {
    logic [4:0]  idx;
    logic [6:0]  ms;
    logic [11:0] vinc;
    logic [15:0] factor;
    logic [15:0] d;
    logic        up;
    band_state_t st;
  } s2_t;

  typedef struct packed {
    logic [4:0]  idx;
    logic [6:0]  ms;
    logic [11:0] vinc;
    logic [31:0] prod;
    logic        up;
    band_state_t st;
  } s3_t;

  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4_next;

  always_comb begin
    s2_next.idx    = front.idx;
    s2_next.ms     = front.ms;
    s2_next.vinc   = front.vinc;
    s2_next.factor = front.factor;
    s2_next.up     = front.target >= old_state.bar;
    s2_next.d      = s2_next.up ? front.target - old_state.bar
                                : old_state.bar - front.target;
    s2_next.st     = old_state;
  end

  always_comb begin
    s3_next.idx  = s2.idx;
    s3_next.ms   = s2.ms;
    s3_next.vinc = s2.vinc;
    s3_next.up   = s2.up;
    s3_next.st   = s2.st;
    s3_next.prod = 32'(s2.d) * 32'(s2.factor) + ROUND_HALF;
  end

  logic [15:0] step;
  logic [16:0] vsum;

  always_comb begin
    step        = s3.prod[31:16];
    vsum        = {1'b0, s3.st.vel} + 17'(s3.vinc);
    s4_next.idx = s3.idx;
    s4_next.ms  = s3.ms;
    s4_next.bar = s3.up ? s3.st.bar + step : s3.st.bar - step;
    s4_next.ge  = s4_next.bar >= s3.st.peak;
    s4_next.peak = s3.st.peak;
    s4_next.vel = vsum[16] ? 16'hFFFF : vsum[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sbs_peak.sv
// sbs_peak: peak fall stages 5..6 (velocity * time, divide by 500 via
// reciprocal), new peak, write-back state and zone split. Uses sbs_pkg.
`default_nettype none

module sbs_peak import sbs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  adv,
  input  s4_t        s4,
  input  zone_cfg_t  zone,
  output band_state_t wr_state,
  output result_t    result
);

  typedef struct packed {
    logic [4:0]  idx;
    logic [15:0] bar;
    logic        ge;
    logic [15:0] peak;
    logic [15:0] vel;
    logic [22:0] y;
  } s5_t;

  typedef struct packed {
    logic [4:0]  idx;
    logic [15:0] bar;
    logic        ge;
    logic [15:0] peak;
    logic [15:0] vel;
    logic [42:0] q;
  } s6_t;

  s5_t s5, s5_next;
  s6_t s6, s6_next;

  always_comb begin
    s5_next.idx  = s4.idx;
    s5_next.bar  = s4.bar;
    s5_next.ge   = s4.ge;
    s5_next.peak = s4.peak;
    s5_next.vel  = s4.vel;
    s5_next.y    = 23'(s4.vel) * 23'(s4.ms) + FALL_ROUND;
  end

  always_comb begin
    s6_next.idx  = s5.idx;
    s6_next.bar  = s5.bar;
    s6_next.ge   = s5.ge;
    s6_next.peak = s5.peak;
    s6_next.vel  = s5.vel;
    s6_next.q    = 43'(s5.y[22:2]) * 43'(FALL_RECIP);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5 <= s5_next;
      s6 <= s6_next;
    end
  end

  logic [15:0] fall;
  logic [15:0] peak_new;
  logic [5:0]  h;
  logic [5:0]  cap;

  always_comb begin
    fall = 16'(s6.q[42:FALL_SHIFT]);
    if (s6.ge) begin
      peak_new = s6.bar;
    end else if (fall >= s6.peak) begin
      peak_new = '0;
    end else begin
      peak_new = s6.peak - fall;
    end
    wr_state.bar  = s6.bar;
    wr_state.peak = peak_new;
    wr_state.vel  = s6.ge ? '0 : s6.vel;

    h   = s6.bar[15:10];
    cap = (h < zone.mid) ? h : zone.mid;
    result.band    = s6.idx;
    result.bar_px  = h;
    result.peak_px = peak_new[15:10];
    result.shown   = peak_new > ONE_PX_Q10;
    result.lo      = (h < zone.low) ? h : zone.low;
    result.mid     = (cap > zone.low) ? cap - zone.low : '0;
    result.top     = (h > zone.mid) ? h - zone.mid : '0;
  end

endmodule

`default_nettype wire

FILE: hdl/spectrum_bar_smoother_peak_hold_top.sv
// Spectrum bar smoother with peak hold, top level: input stage, table
// lookups, band hazard check, config registers and output register.
// Depends on sbs_pkg, sbs_state_ram, sbs_smooth and sbs_peak.
//
// Usage: one band request per cycle on in_valid/in_stall (band_index,
// band_level, stale, elapsed_ms); one result per request on out_valid/
// out_stall, in request order. A request is taken when valid is high and
// stall is low on a rising edge of clk.
// Each request passes the input stage, stages 2..6 and the output register.
// Throughput: one request per cycle for requests to different bands. A
// request whose band (band_index mod BANDS) matches one of the up to six
// requests in the pipeline is held by in_stall until that band's state is
// written back, so back-to-back updates of one band do not overlap.
// When out_stall is high with a result waiting, the whole pipeline holds
// and in_stall is raised; nothing is dropped or repeated.
// Reset (rst, synchronous): all bands read as zero height and velocity,
// smoothing_mode = 0, zone tops 28 and 45; in_stall is high during reset.
// Config writes (cfg_wr_en, cfg_index, cfg_data) take effect next cycle
// and are meant to be issued while the block is idle.
`default_nettype none

module spectrum_bar_smoother_peak_hold_top import sbs_pkg::*; #(
  parameter int BANDS = BANDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [4:0]  band_index,
  input  wire logic [7:0]  band_level,
  input  wire logic        stale,
  input  wire logic [15:0] elapsed_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       band_out,
  output logic [5:0]       bar_pixels,
  output logic [5:0]       peak_pixels,
  output logic             peak_shown,
  output logic [5:0]       low_part,
  output logic [5:0]       mid_part,
  output logic [5:0]       top_part
);

  localparam int          SLOT_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam logic [12:0] BANDS_W = 13'(BANDS);

  logic        smoothing_mode;
  zone_cfg_t   zone;

  logic        adv;
  logic        hazard;
  logic        in_accept;
  logic [4:0]  rem;
  logic [SLOT_W-1:0] in_slot;
  logic [6:0]  ms_sat;
  front_t      front, front_next;

  logic [PIPE_DEPTH:1] vld;
  logic [SLOT_W-1:0]   slot_pipe [1:PIPE_DEPTH];

  band_state_t old_state;
  band_state_t wr_state;
  s4_t         s4;
  result_t     result, result_out;

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = rst || !adv || hazard;
  assign in_accept = in_valid && !in_stall;

  // band_index mod BANDS by restoring subtraction
  always_comb begin
    rem = band_index;
    for (int k = 4; k >= 0; k--) begin
      if (13'(rem) >= (BANDS_W << k)) begin
        rem = rem - 5'(BANDS_W << k);
      end
    end
    in_slot = SLOT_W'(rem);
  end

  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= PIPE_DEPTH; k++) begin
      if (vld[k] && slot_pipe[k] == in_slot) begin
        hazard = 1'b1;
      end
    end
  end

  always_comb begin
    ms_sat            = (elapsed_ms > 16'(DT_MAX)) ? 7'(DT_MAX) : elapsed_ms[6:0];
    front_next.idx    = band_index;
    front_next.target = stale ? '0 : TGT_ROM[band_level];
    front_next.ms     = ms_sat;
    front_next.factor = smoothing_mode ? FAC_ROM[ms_sat] : FIX_SMOOTH;
    front_next.vinc   = VINC_ROM[ms_sat];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front      <= front_next;
      result_out <= result;
      slot_pipe[1] <= in_slot;
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
        slot_pipe[k] <= slot_pipe[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld            <= '0;
      out_valid      <= 1'b0;
      smoothing_mode <= 1'b0;
      zone.low       <= LOW_TOP_DEF;
      zone.mid       <= MID_TOP_DEF;
    end else begin
      if (adv) begin
        vld       <= {vld[PIPE_DEPTH-1:1], in_accept};
        out_valid <= vld[PIPE_DEPTH];
      end
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SMOOTHING_MODE: smoothing_mode <= cfg_data[0];
          CFG_LOW_ZONE_TOP:   zone.low       <= cfg_data;
          CFG_MID_ZONE_TOP:   zone.mid       <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  sbs_state_ram #(
    .BANDS  (BANDS),
    .SLOT_W (SLOT_W)
  ) u_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (adv),
    .rd_slot  (in_slot),
    .rd_state (old_state),
    .wr_en    (adv && vld[PIPE_DEPTH]),
    .wr_slot  (slot_pipe[PIPE_DEPTH]),
    .wr_state (wr_state)
  );

  sbs_smooth u_smooth (
    .clk       (clk),
    .adv       (adv),
    .front     (front),
    .old_state (old_state),
    .s4        (s4)
  );

  sbs_peak u_peak (
    .clk      (clk),
    .adv      (adv),
    .s4       (s4),
    .zone     (zone),
    .wr_state (wr_state),
    .result   (result)
  );

  assign band_out    = result_out.band;
  assign bar_pixels  = result_out.bar_px;
  assign peak_pixels = result_out.peak_px;
  assign peak_shown  = result_out.shown;
  assign low_part    = result_out.lo;
  assign mid_part    = result_out.mid;
  assign top_part    = result_out.top;

endmodule

`default_nettype wire

FILE: tb/spectrum_bar_smoother_peak_hold_top_test.sv
// Self-checking testbench for spectrum_bar_smoother_peak_hold_top: drives band
// requests with random gaps and output stalls and checks every result against a
// built-in smoother and peak-hold predictor. Depends on sbs_pkg and the top only.
`timescale 1ns / 100ps

module spectrum_bar_smoother_peak_hold_top_test;
  import sbs_pkg::*;

  typedef struct {
    logic [4:0]  idx;
    logic [7:0]  level;
    logic        stale;
    logic [15:0] ms;
  } band_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  band_index = '0;
  logic [7:0]  band_level = '0;
  logic        stale = 1'b0;
  logic [15:0] elapsed_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  band_out;
  logic [5:0]  bar_pixels;
  logic [5:0]  peak_pixels;
  logic        peak_shown;
  logic [5:0]  low_part;
  logic [5:0]  mid_part;
  logic [5:0]  top_part;

  // predictor state and register copies
  logic [15:0] bar_q10 [BANDS_DEF];
  logic [15:0] peak_q10 [BANDS_DEF];
  logic [15:0] fall_vel [BANDS_DEF];
  logic [15:0] exp_factor [DT_MAX+1];
  logic        smooth_mode = 1'b0;
  logic [5:0]  low_top = LOW_TOP_DEF;
  logic [5:0]  mid_top = MID_TOP_DEF;

  band_req_t band_reqs [$];
  result_t   expected_bars [$];
  band_req_t next_req;
  result_t   want;
  int        outstanding = 0;
  int        errors = 0;
  int        idle_pct = 0;
  int        in_gap = 0;
  int        stall_left = 0;
  int        level_mem [BANDS_DEF];
  int        stale_run = 0;

  spectrum_bar_smoother_peak_hold_top u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .band_index (band_index),
    .band_level (band_level),
    .stale      (stale),
    .elapsed_ms (elapsed_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .band_out   (band_out),
    .bar_pixels (bar_pixels),
    .peak_pixels(peak_pixels),
    .peak_shown (peak_shown),
    .low_part   (low_part),
    .mid_part   (mid_part),
    .top_part   (top_part)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(string what, int got, int want_val);
    if (errors < 100) begin
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want_val);
    end
    errors++;
  endtask

  function automatic result_t smooth_band(input logic [4:0] idx, input logic [7:0] level,
                                          input logic is_stale, input logic [15:0] ms);
    int unsigned     dt, target, factor, bar, peak, vel, fall, h, cap;
    longint unsigned d;
    result_t         r;
    dt = (ms > 16'(DT_MAX)) ? 32'(DT_MAX) : 32'(ms);
    target = is_stale ? 0 : (int'(level) * 57344 + 127) / 255;
    factor = smooth_mode ? 32'(exp_factor[dt]) : 32'(FIX_SMOOTH);
    bar = 32'(bar_q10[idx]);
    if (target >= bar) begin
      d = 64'(target - bar);
      bar = bar + 32'((d * factor + 64'd32768) >> 16);
    end else begin
      d = 64'(bar - target);
      bar = bar - 32'((d * factor + 64'd32768) >> 16);
    end
    bar = bar & 32'hFFFF;
    peak = 32'(peak_q10[idx]);
    vel = 32'(fall_vel[idx]);
    if (bar >= peak) begin
      peak = bar;
      vel = 0;
    end else begin
      vel = vel + (30720 * dt + 500) / 1000;
      if (vel > 32'hFFFF) vel = 32'hFFFF;
      fall = (vel * dt + 250) / 500;
      if (fall >= peak) peak = 0;
      else peak = peak - fall;
    end
    bar_q10[idx] = 16'(bar);
    peak_q10[idx] = 16'(peak);
    fall_vel[idx] = 16'(vel);
    h = bar >> 10;
    cap = (h < mid_top) ? h : 32'(mid_top);
    r.band = idx;
    r.bar_px = 6'(h);
    r.peak_px = 6'(peak >> 10);
    r.shown = (peak > 1024);
    r.lo = 6'((h < low_top) ? h : 32'(low_top));
    r.mid = 6'((cap > low_top) ? cap - low_top : 0);
    r.top = 6'((h > mid_top) ? h - mid_top : 0);
    return r;
  endfunction

  task automatic write_cfg(cfg_reg_t which, logic [5:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    case (which)
      CFG_SMOOTHING_MODE: smooth_mode = value[0];
      CFG_LOW_ZONE_TOP:   low_top = value;
      CFG_MID_ZONE_TOP:   mid_top = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic add_req(logic [4:0] idx, logic [7:0] level, logic st, logic [15:0] ms);
    band_req_t req;
    req.idx = idx;
    req.level = level;
    req.stale = st;
    req.ms = ms;
    band_reqs.push_back(req);
  endtask

  // frames: a sweep over neighboring bands sharing one frame time and stale flag,
  // levels drifting per band; about one in ten draws adds a single pure-noise request
  task automatic queue_frames(int n);
    int          made, count, first, slot, lvl, kind;
    logic [15:0] ms;
    logic        frame_stale;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) == 0) begin
        add_req(5'($urandom), 8'($urandom), 1'($urandom), 16'($urandom));
        made++;
      end else begin
        kind = $urandom_range(0, 9);
        if (kind < 6) ms = 16'($urandom_range(5, 40));
        else if (kind == 6) ms = 16'd0;
        else if (kind < 9) ms = 16'($urandom_range(41, 120));
        else ms = 16'($urandom);
        if (stale_run == 0 && $urandom_range(0, 9) == 0) stale_run = $urandom_range(1, 40);
        frame_stale = (stale_run != 0);
        if (stale_run != 0) stale_run--;
        count = $urandom_range(4, 32);
        first = $urandom_range(0, 31);
        for (int k = 0; k < count; k++) begin
          slot = (first + k) % BANDS_DEF;
          case ($urandom_range(0, 9))
            0: lvl = 0;
            1: lvl = 255;
            2, 3: lvl = $urandom_range(0, 255);
            default: lvl = level_mem[slot] + int'($urandom_range(0, 60)) - 30;
          endcase
          if (lvl < 0) lvl = 0;
          if (lvl > 255) lvl = 255;
          level_mem[slot] = lvl;
          add_req(5'(slot), 8'(lvl), frame_stale, ms);
        end
        made += count;
      end
    end
  endtask

  task automatic drain();
    while (band_reqs.size() != 0 || outstanding != 0) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_bars.push_back(smooth_band(band_index, band_level, stale, elapsed_ms));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (band_reqs.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
          in_gap = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (band_reqs.size() != 0) begin
          next_req = band_reqs.pop_front();
          outstanding++;
          in_valid <= 1'b1;
          band_index <= next_req.idx;
          band_level <= next_req.level;
          stale <= next_req.stale;
          elapsed_ms <= next_req.ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_bars.size() == 0) begin
        report("unexpected result, band_out", band_out, -1);
      end else begin
        want = expected_bars.pop_front();
        outstanding--;
        if (band_out !== want.band) report("band_out", band_out, want.band);
        if (bar_pixels !== want.bar_px) report("bar_pixels", bar_pixels, want.bar_px);
        if (peak_pixels !== want.peak_px) report("peak_pixels", peak_pixels, want.peak_px);
        if (peak_shown !== want.shown) report("peak_shown", peak_shown, want.shown);
        if (low_part !== want.lo) report("low_part", low_part, want.lo);
        if (mid_part !== want.mid) report("mid_part", mid_part, want.mid);
        if (top_part !== want.top) report("top_part", top_part, want.top);
      end
    end
  end

  initial begin
    longint unsigned p;
    p = 64'd1 << 32;
    for (int k = 0; k <= DT_MAX; k++) begin
      exp_factor[k] = 16'(64'd65536 - ((p + 64'd32768) >> 16));
      p = (p * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    for (int i = 0; i < BANDS_DEF; i++) begin
      bar_q10[i] = '0;
      peak_q10[i] = '0;
      fall_vel[i] = '0;
      level_mem[i] = $urandom_range(0, 255);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings, fixed factor: full scale, saturated time, stale, bit patterns
    idle_pct = 12;
    add_req(5'd0, 8'd255, 1'b0, 16'd0);
    add_req(5'd0, 8'd255, 1'b0, 16'd20);
    add_req(5'd0, 8'd0, 1'b0, 16'hFFFF);
    add_req(5'd0, 8'd0, 1'b0, 16'd0);
    add_req(5'd0, 8'd0, 1'b1, 16'd101);
    add_req(5'd31, 8'd255, 1'b0, 16'd100);
    add_req(5'd31, 8'd200, 1'b1, 16'h5555);
    add_req(5'h15, 8'hAA, 1'b0, 16'hAAAA);
    add_req(5'h0A, 8'h55, 1'b0, 16'h5555);
    add_req(5'd31, 8'd0, 1'b0, 16'h8000);
    add_req(5'd1, 8'd1, 1'b0, 16'd1);
    add_req(5'd2, 8'd254, 1'b0, 16'd99);
    add_req(5'd31, 8'd255, 1'b0, 16'd100);
    queue_frames(140);
    drain();

    // exponential factor, whole bar in the middle zone; zero time holds bar and peak
    write_cfg(CFG_SMOOTHING_MODE, 6'd1);
    write_cfg(CFG_LOW_ZONE_TOP, 6'd0);
    write_cfg(CFG_MID_ZONE_TOP, 6'd56);
    idle_pct = 20;
    add_req(5'd3, 8'd255, 1'b0, 16'd0);
    add_req(5'd3, 8'd255, 1'b0, 16'd1);
    add_req(5'd3, 8'd255, 1'b0, 16'd100);
    add_req(5'd3, 8'd255, 1'b0, 16'hFFFF);
    add_req(5'd3, 8'd0, 1'b0, 16'd0);
    add_req(5'd3, 8'd0, 1'b0, 16'd50);
    add_req(5'd3, 8'd0, 1'b0, 16'd0);
    queue_frames(150);
    drain();

    // middle zone top below the low zone top
    write_cfg(CFG_LOW_ZONE_TOP, 6'd56);
    write_cfg(CFG_MID_ZONE_TOP, 6'd0);
    idle_pct = 6;
    queue_frames(150);
    drain();

    // zone tops beyond the bar range, fixed factor, no idling
    write_cfg(CFG_SMOOTHING_MODE, 6'd0);
    write_cfg(CFG_LOW_ZONE_TOP, 6'd63);
    write_cfg(CFG_MID_ZONE_TOP, 6'd63);
    idle_pct = 0;
    queue_frames(140);
    drain();

    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (expected_bars.size() != 0) report("results never returned", 0, expected_bars.size());
    if (errors == 0) begin
      $display("spectrum_bar_smoother_peak_hold_top_test: done, clean");
    end else begin
      $display("spectrum_bar_smoother_peak_hold_top_test: done, errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("spectrum_bar_smoother_peak_hold_top_test: done, errors");
    $finish;
  end

endmodule
